/* rtl/core/sorted_symbol_count_table_unit_macros.svh */
// ----------------------------------------------------------------------------
// Sorted symbol count table: assertion macros
// Clocked, reset-qualified assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_SYMBOL_COUNT_TABLE_UNIT_MACROS_SVH
`define SORTED_SYMBOL_COUNT_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define SSCT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ssct checker: same-cycle property failed");

// Next-cycle implication, checked on every rising edge outside reset
`define SSCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ssct checker: next-cycle property failed");

`endif

/* rtl/core/ssct_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted symbol count table package
// Beat types, item kinds, sequencer states and shared constants.
// ----------------------------------------------------------------------------
package ssct_pkg;

    // default table depth
    localparam int ENTRIES_DEF = 256;

    // fixed field widths
    localparam int SYM_W   = 16;
    localparam int CNT_W   = 16;
    localparam int POS_W   = 9;
    localparam int USAGE_W = 32;

    // saturation point of an entry count
    localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // item kinds; the unused code behaves as a find
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_FIND  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // input beat
    typedef struct packed {
        logic [1:0]       kind;
        logic [SYM_W-1:0] symbol;
    } t_in;

    // result beat
    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
        logic [CNT_W-1:0]   count;
        logic [USAGE_W-1:0] usage;
        logic               full_res;
    } t_out;

    // one table entry as held in memory
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic [CNT_W-1:0] count;
    } t_entry;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_COMPARE,
        S_PROBE,
        S_CHECK,
        S_SHIFT_START,
        S_SHIFT,
        S_INSERT
    } t_state;

endpackage

/* rtl/core/sorted_symbol_count_table_unit.sv */
// ----------------------------------------------------------------------------
// Sorted symbol count table unit
// Ascending table of symbols with saturating counts, held in one memory and
// worked by a small sequencer: binary search, probe, shift-up insert.
// ----------------------------------------------------------------------------
//  channel  | handshake            | beat
//  ---------+----------------------+------------------------------------
//  item     | start high, busy low | i_item  (kind, symbol)
//  result   | o_strobe, one cycle  | o_result (found, position, count,
//           |                      |           usage, full_res)
//
//  A clear leaves busy low and its result strobes in the next cycle.
//  Add and find run a binary search over the filled entries and a probe;
//  an add that inserts then moves the entries from the position on up by one,
//  one entry per cycle through the single read and write memory port.
//  Reset clears the fill count and usage; entry memory needs no clearing.
//  The result is shown for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module sorted_symbol_count_table_unit #(
    parameter int ENTRIES = ssct_pkg::ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ssct_pkg::t_in i_item,
    output logic          o_strobe,
    output ssct_pkg::t_out o_result
);

    localparam int IDX_W = $clog2(ENTRIES + 1);
    localparam int AW    = $clog2(ENTRIES);

    // entry memory
    ssct_pkg::t_entry r_mem [ENTRIES];
    ssct_pkg::t_entry r_rd_data;
    ssct_pkg::t_entry wr_data;
    logic             rd_en;
    logic             wr_en;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;

    // control registers
    ssct_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0] r_used, n_used;
    logic [ssct_pkg::USAGE_W-1:0] r_usage, n_usage;
    logic             r_strobe, n_strobe;

    // payload registers
    ssct_pkg::t_in    r_item, n_item;
    logic [IDX_W-1:0] r_lo, n_lo;
    logic [IDX_W-1:0] r_hi, n_hi;
    logic [IDX_W-1:0] r_mid, n_mid;
    logic [IDX_W-1:0] r_k, n_k;
    logic             r_probe, n_probe;
    ssct_pkg::t_out   r_result, n_result;

    // shared datapath terms
    logic [IDX_W-1:0] mid;
    logic [IDX_W-1:0] km1;
    logic             hit;
    logic [ssct_pkg::CNT_W-1:0] cnt_inc;
    logic [ssct_pkg::POS_W+IDX_W-1:0] pos_ext;
    logic [ssct_pkg::POS_W-1:0] pos_out;

    assign mid     = r_lo + ((r_hi - r_lo) >> 1);
    assign km1     = r_k - IDX_W'(1);
    assign hit     = r_probe && (r_rd_data.symbol == r_item.symbol);
    assign cnt_inc = r_rd_data.count + ssct_pkg::CNT_W'(1);
    assign pos_ext = {{ssct_pkg::POS_W{1'b0}}, r_lo};
    assign pos_out = pos_ext[ssct_pkg::POS_W-1:0];

    // memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ssct_pkg::S_IDLE;
            r_used   <= '0;
            r_usage  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_usage  <= n_usage;
            r_strobe <= n_strobe;
        end
    end

    // working payload
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_k      <= n_k;
        r_probe  <= n_probe;
        r_result <= n_result;
    end

    // sequencer: next state, memory controls, result
    always_comb begin
        n_state  = r_state;
        n_used   = r_used;
        n_usage  = r_usage;
        n_strobe = 1'b0;
        n_item   = r_item;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_k      = r_k;
        n_probe  = r_probe;
        n_result = r_result;
        rd_en    = 1'b0;
        rd_addr  = r_lo[AW-1:0];
        wr_en    = 1'b0;
        wr_addr  = r_lo[AW-1:0];
        wr_data  = r_rd_data;

        unique case (r_state)
            ssct_pkg::S_IDLE: begin
                if (start) begin
                    n_item = i_item;
                    if (i_item.kind == ssct_pkg::KIND_CLEAR) begin
                        n_used   = '0;
                        n_usage  = '0;
                        n_result = '0;
                        n_strobe = 1'b1;
                    end else begin
                        n_lo    = '0;
                        n_hi    = r_used;
                        n_state = ssct_pkg::S_SEARCH;
                    end
                end
            end

            // lower-bound search: each probe reads the middle entry, S_COMPARE halves the range
            ssct_pkg::S_SEARCH: begin
                if (r_lo < r_hi) begin
                    rd_en   = 1'b1;
                    rd_addr = mid[AW-1:0];
                    n_mid   = mid;
                    n_state = ssct_pkg::S_COMPARE;
                end else begin
                    n_state = ssct_pkg::S_PROBE;
                end
            end

            ssct_pkg::S_COMPARE: begin
                if (r_rd_data.symbol < r_item.symbol) begin
                    n_lo = r_mid + IDX_W'(1);
                end else begin
                    n_hi = r_mid;
                end
                n_state = ssct_pkg::S_SEARCH;
            end

            // fetch the entry at the insertion point, if it exists
            ssct_pkg::S_PROBE: begin
                n_probe = (r_lo < r_used);
                rd_en   = (r_lo < r_used);
                rd_addr = r_lo[AW-1:0];
                n_state = ssct_pkg::S_CHECK;
            end

            ssct_pkg::S_CHECK: begin
                n_result.found    = hit;
                n_result.position = pos_out;
                n_result.count    = '0;
                n_result.usage    = r_usage;
                n_result.full_res = 1'b0;
                priority if (r_item.kind != ssct_pkg::KIND_ADD) begin
                    if (hit) begin
                        n_result.count = r_rd_data.count;
                    end
                    n_strobe = 1'b1;
                    n_state  = ssct_pkg::S_IDLE;
                end else if (hit) begin
                    // present: saturating increment in place
                    if (r_rd_data.count != ssct_pkg::COUNT_MAX) begin
                        wr_en          = 1'b1;
                        wr_data.symbol = r_rd_data.symbol;
                        wr_data.count  = cnt_inc;
                        n_usage        = r_usage + ssct_pkg::USAGE_W'(1);
                        n_result.count = cnt_inc;
                        n_result.usage = r_usage + ssct_pkg::USAGE_W'(1);
                    end else begin
                        n_result.count = r_rd_data.count;
                    end
                    n_strobe = 1'b1;
                    n_state  = ssct_pkg::S_IDLE;
                end else if (r_used >= IDX_W'(ENTRIES)) begin
                    // missing and no room: refuse
                    n_result.full_res = 1'b1;
                    n_strobe          = 1'b1;
                    n_state           = ssct_pkg::S_IDLE;
                end else begin
                    n_k     = r_used;
                    n_state = ssct_pkg::S_SHIFT_START;
                end
            end

            // prime the shift-up pipeline with the last entry
            ssct_pkg::S_SHIFT_START: begin
                if (r_k > r_lo) begin
                    rd_en   = 1'b1;
                    rd_addr = km1[AW-1:0];
                    n_state = ssct_pkg::S_SHIFT;
                end else begin
                    n_state = ssct_pkg::S_INSERT;
                end
            end

            // write entry k-1 into k while reading k-2
            ssct_pkg::S_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = r_k[AW-1:0];
                wr_data = r_rd_data;
                n_k     = km1;
                if (km1 > r_lo) begin
                    rd_en   = 1'b1;
                    rd_addr = km1[AW-1:0] - AW'(1);
                end else begin
                    n_state = ssct_pkg::S_INSERT;
                end
            end

            // new entry starts at one
            ssct_pkg::S_INSERT: begin
                wr_en             = 1'b1;
                wr_addr           = r_lo[AW-1:0];
                wr_data.symbol    = r_item.symbol;
                wr_data.count     = ssct_pkg::CNT_W'(1);
                n_used            = r_used + IDX_W'(1);
                n_usage           = r_usage + ssct_pkg::USAGE_W'(1);
                n_result.found    = 1'b0;
                n_result.position = pos_out;
                n_result.count    = ssct_pkg::CNT_W'(1);
                n_result.usage    = r_usage + ssct_pkg::USAGE_W'(1);
                n_result.full_res = 1'b0;
                n_strobe          = 1'b1;
                n_state           = ssct_pkg::S_IDLE;
            end

            default: begin
                n_state = ssct_pkg::S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != ssct_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

/* rtl/core/ssct_checker.sv */
// ----------------------------------------------------------------------------
// Sorted symbol count table port checker
// Watches the top-level ports for result consistency over time.
// ----------------------------------------------------------------------------
`include "sorted_symbol_count_table_unit_macros.svh"

module ssct_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input ssct_pkg::t_in  i_item,
    input logic           o_strobe,
    input ssct_pkg::t_out o_result
);

    // a clear beat answers next cycle with an all-zero result
    `SSCT_ASSERT_NEXT(a_clear_result, start && !busy && (i_item.kind == ssct_pkg::KIND_CLEAR), o_strobe && (o_result == '0))

    // an add or find beat keeps the unit occupied for the search
    `SSCT_ASSERT_NEXT(a_search_busy, start && !busy && (i_item.kind != ssct_pkg::KIND_CLEAR), busy && !o_strobe)

    // a refused insert never reports a present symbol or a count
    `SSCT_ASSERT_NOW(a_full_clean, o_strobe && o_result.full_res, !o_result.found && (o_result.count == '0))

    // a symbol not present before ends with count zero or a fresh one
    `SSCT_ASSERT_NOW(a_miss_count, o_strobe && !o_result.found, (o_result.count == 16'd0) || (o_result.count == 16'd1))

endmodule

bind sorted_symbol_count_table_unit ssct_checker u_ssct_checker (.*);
